// ----- src/pdmc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdmc_pkg
// Types and constants shared by the per-channel delay mean calibrator.
// ----------------------------------------------------------------------------
package pdmc_pkg;

    localparam int CHAN_W     = 11;
    localparam int CHAN_EXT_W = 13;
    localparam int TENTHS_W   = 11;
    localparam int CMD_W      = 2;
    localparam int CNT_W      = 24;
    localparam int SUM_W      = 35;
    localparam int LIMIT_W    = 18;
    localparam int MINC_W     = 16;
    localparam int MEAN_W     = 18;
    localparam int STATUS_W   = 2;
    localparam int EPOCH_W    = 8;
    localparam int PROD_W     = 42;
    localparam int NUM_W      = 44;
    localparam int DIV_W      = 25;
    localparam int QUO_W      = 18;
    localparam int STEP_W     = 5;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CMD_W-1:0] CMD_HIT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVENT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [1:0] REG_HIGH_LIMIT = 2'd1;
    localparam logic [1:0] REG_MIN_COUNTS = 2'd2;

    localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 18'd50000;
    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 18'd109000;
    localparam logic [MINC_W-1:0]  MIN_COUNTS_RST = 16'd20;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NODATA = 2'd3;

    localparam logic [MEAN_W-1:0]   MEAN_FEW  = 18'd80123;
    localparam logic [MEAN_W-1:0]   MEAN_OUT  = 18'd56000;
    localparam logic [TENTHS_W-1:0] D_LOW     = 11'd500;
    localparam logic [TENTHS_W-1:0] D_HIGH    = 11'd1090;
    localparam logic [CNT_W-1:0]    COUNT_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        OP_HIT,
        OP_EVENT,
        OP_QUERY,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        B_INIT,
        B_RUN,
        B_WRAP
    } back_state_t;

    typedef enum logic [2:0] {
        Q_IDLE,
        Q_MUL,
        Q_CMP,
        Q_DIV,
        Q_DONE
    } query_state_t;

    typedef struct packed {
        op_t                 op;
        logic [CHAN_W-1:0]   channel;
        logic                ch_ok;
        logic [TENTHS_W-1:0] tenths;
        logic                good;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
    } acc_t;

    typedef struct packed {
        logic ch_ok;
        logic seen;
        acc_t acc;
    } qreq_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] low_limit;
        logic [LIMIT_W-1:0] high_limit;
        logic [MINC_W-1:0]  min_counts;
    } cfg_t;

endpackage
`default_nettype wire

// ----- src/pdmc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdmc_front
// Input side: decodes each word, clamps the delay, checks the channel range
// and pushes the classified word into the queue.
// ----------------------------------------------------------------------------
module pdmc_front #(
    parameter int CHANNELS = 2048
) (
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [pdmc_pkg::CMD_W-1:0]       s_command,
    input  wire logic [pdmc_pkg::CHAN_W-1:0]      s_channel,
    input  wire logic [pdmc_pkg::TENTHS_W-1:0]    s_d80_tenths,
    input  wire logic                             s_hit_good,
    input  wire logic                             q_ready,
    input  wire logic                             init_busy,
    output logic                                  push,
    output pdmc_pkg::item_t                       item
);

    always_comb begin
        case (s_command)
            pdmc_pkg::CMD_HIT:   item.op = pdmc_pkg::OP_HIT;
            pdmc_pkg::CMD_EVENT: item.op = pdmc_pkg::OP_EVENT;
            pdmc_pkg::CMD_QUERY: item.op = pdmc_pkg::OP_QUERY;
            default:             item.op = pdmc_pkg::OP_NONE;
        endcase
        item.channel = s_channel;
        item.ch_ok   = pdmc_pkg::CHAN_EXT_W'(s_channel) < pdmc_pkg::CHAN_EXT_W'(CHANNELS);
        if (s_d80_tenths < pdmc_pkg::D_LOW) begin
            item.tenths = pdmc_pkg::D_LOW;
        end else if (s_d80_tenths > pdmc_pkg::D_HIGH) begin
            item.tenths = pdmc_pkg::D_HIGH;
        end else begin
            item.tenths = s_d80_tenths;
        end
        item.good = s_hit_good;
    end

    assign s_ready = q_ready & ~init_busy;
    // unused command code is dropped here
    assign push    = s_valid & s_ready & (item.op != pdmc_pkg::OP_NONE);

endmodule
`default_nettype wire

// ----- src/pdmc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdmc_queue
// Short word queue between the input side and the execution side.
// ----------------------------------------------------------------------------
module pdmc_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire pdmc_pkg::item_t push_item,
    output logic                 q_ready,
    input  wire logic            pop,
    output pdmc_pkg::item_t      head,
    output logic                 head_valid
);

    pdmc_pkg::item_t                mem_reg [pdmc_pkg::QUEUE_DEPTH];
    logic [pdmc_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [pdmc_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [pdmc_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign q_ready    = count_reg != pdmc_pkg::QCNT_W'(pdmc_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ----- src/pdmc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdmc_back
// Execution side: per-channel count/sum store and event marks, first-hit
// filter, store and mark clearing passes and hand-off of queries to the mean unit.
// ----------------------------------------------------------------------------
module pdmc_back #(
    parameter int CHANNELS = 2048
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire pdmc_pkg::item_t  head,
    input  wire logic             head_valid,
    output logic                  pop,
    output logic                  init_busy,
    output logic                  q_start,
    output pdmc_pkg::qreq_t       q_req,
    input  wire logic             q_busy
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

    function automatic logic [IW-1:0] idx_of(input logic [pdmc_pkg::CHAN_W-1:0] ch);
        logic [pdmc_pkg::CHAN_EXT_W-1:0] w;
        w = pdmc_pkg::CHAN_EXT_W'(ch);
        return w[IW-1:0];
    endfunction

    pdmc_pkg::acc_t                  data_mem [CHANNELS];
    logic [pdmc_pkg::EPOCH_W-1:0]    tag_mem  [CHANNELS];

    pdmc_pkg::back_state_t           state_reg, state_next;
    logic [IW-1:0]                   sweep_reg, sweep_next;
    logic [pdmc_pkg::EPOCH_W-1:0]    epoch_reg, epoch_next;
    logic                            seen_reg, seen_next;
    logic                            ex_valid_reg, ex_valid_next;
    pdmc_pkg::item_t                 ex_item_reg;
    logic                            fwd_reg;
    pdmc_pkg::acc_t                  fwd_acc_reg;
    logic [pdmc_pkg::EPOCH_W-1:0]    fwd_tag_reg;
    pdmc_pkg::acc_t                  rd_acc_reg;
    logic [pdmc_pkg::EPOCH_W-1:0]    rd_tag_reg;

    pdmc_pkg::acc_t                  cur_acc, new_acc, wr_acc;
    logic [pdmc_pkg::EPOCH_W-1:0]    cur_tag, new_tag, wr_tag;
    logic [IW-1:0]                   ex_idx, head_idx, wr_idx;
    logic                            is_hit, is_event, is_query;
    logic                            hit_act, acc_upd, ex_done, wrap_start, fwd_hit;
    logic                            dwe, twe;

    assign ex_idx   = idx_of(ex_item_reg.channel);
    assign head_idx = idx_of(head.channel);

    // same-channel word right behind a hit reads the store before the write lands
    assign cur_acc = fwd_reg ? fwd_acc_reg : rd_acc_reg;
    assign cur_tag = fwd_reg ? fwd_tag_reg : rd_tag_reg;

    always_comb begin
        is_hit     = ex_valid_reg & (ex_item_reg.op == pdmc_pkg::OP_HIT);
        is_event   = ex_valid_reg & (ex_item_reg.op == pdmc_pkg::OP_EVENT);
        is_query   = ex_valid_reg & (ex_item_reg.op == pdmc_pkg::OP_QUERY);
        hit_act    = is_hit & ex_item_reg.ch_ok & (cur_tag != epoch_reg);
        acc_upd    = hit_act & ex_item_reg.good & (cur_acc.cnt != pdmc_pkg::COUNT_MAX);
        new_acc.cnt = acc_upd ? cur_acc.cnt + 1'b1 : cur_acc.cnt;
        new_acc.sum = acc_upd ? cur_acc.sum + pdmc_pkg::SUM_W'(ex_item_reg.tenths)
                              : cur_acc.sum;
        new_tag    = hit_act ? epoch_reg : cur_tag;
        ex_done    = ex_valid_reg & ~(is_query & q_busy);
        wrap_start = is_event & (epoch_reg == '1);
        pop        = head_valid & (state_reg == pdmc_pkg::B_RUN) & ~wrap_start
                     & (~ex_valid_reg | ex_done);
        fwd_hit    = is_hit & ex_item_reg.ch_ok & head.ch_ok
                     & (head.channel == ex_item_reg.channel);
        q_start    = is_query & ~q_busy;
        q_req.ch_ok = ex_item_reg.ch_ok;
        q_req.seen  = seen_reg;
        q_req.acc   = cur_acc;
        ex_valid_next = pop | (ex_valid_reg & ~ex_done);
        seen_next     = seen_reg | is_hit;
        init_busy     = state_reg == pdmc_pkg::B_INIT;
    end

    always_comb begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        epoch_next = epoch_reg;
        dwe        = 1'b0;
        twe        = 1'b0;
        wr_idx     = ex_idx;
        wr_acc     = new_acc;
        wr_tag     = epoch_reg;
        case (state_reg)
            pdmc_pkg::B_INIT: begin
                dwe    = 1'b1;
                twe    = 1'b1;
                wr_idx = sweep_reg;
                wr_acc = '0;
                wr_tag = '0;
                if (sweep_reg == LAST_IDX) begin
                    sweep_next = '0;
                    state_next = pdmc_pkg::B_RUN;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            pdmc_pkg::B_RUN: begin
                dwe = acc_upd;
                twe = hit_act;
                if (wrap_start) begin
                    epoch_next = pdmc_pkg::EPOCH_W'(1);
                    state_next = pdmc_pkg::B_WRAP;
                end else if (is_event) begin
                    epoch_next = epoch_reg + 1'b1;
                end
            end
            pdmc_pkg::B_WRAP: begin
                twe    = 1'b1;
                wr_idx = sweep_reg;
                wr_tag = '0;
                if (sweep_reg == LAST_IDX) begin
                    sweep_next = '0;
                    state_next = pdmc_pkg::B_RUN;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            default: begin
                sweep_next = '0;
                state_next = pdmc_pkg::B_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pdmc_pkg::B_INIT;
            sweep_reg    <= '0;
            epoch_reg    <= pdmc_pkg::EPOCH_W'(1);
            seen_reg     <= 1'b0;
            ex_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            epoch_reg    <= epoch_next;
            seen_reg     <= seen_next;
            ex_valid_reg <= ex_valid_next;
            if (pop) begin
                fwd_reg <= fwd_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ex_item_reg <= head;
            fwd_acc_reg <= new_acc;
            fwd_tag_reg <= new_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (dwe) begin
            data_mem[wr_idx] <= wr_acc;
        end
        if (twe) begin
            tag_mem[wr_idx] <= wr_tag;
        end
        if (pop) begin
            rd_acc_reg <= data_mem[head_idx];
            rd_tag_reg <= tag_mem[head_idx];
        end
    end

endmodule
`default_nettype wire

// ----- src/pdmc_query.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdmc_query
// Mean unit: fallback decisions, limit test on the exact mean, rounded
// mean by a radix-2 divider, and the result word register.
// ----------------------------------------------------------------------------
module pdmc_query (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_start,
    input  wire pdmc_pkg::qreq_t                 q_req,
    input  wire pdmc_pkg::cfg_t                  cfg,
    output logic                                 q_busy,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [pdmc_pkg::MEAN_W-1:0]          m_mean_milli,
    output logic [pdmc_pkg::STATUS_W-1:0]        m_status
);

    pdmc_pkg::query_state_t          state_reg, state_next;
    logic [pdmc_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [pdmc_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [pdmc_pkg::PROD_W-1:0]     s100_reg, s100_next;
    logic [pdmc_pkg::PROD_W-1:0]     lo_prod_reg, lo_prod_next;
    logic [pdmc_pkg::PROD_W-1:0]     hi_prod_reg, hi_prod_next;
    logic [pdmc_pkg::DIV_W-1:0]      rem_reg, rem_next;
    logic [pdmc_pkg::QUO_W-1:0]      numlo_reg, numlo_next;
    logic [pdmc_pkg::QUO_W-1:0]      quo_reg, quo_next;
    logic [pdmc_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [pdmc_pkg::MEAN_W-1:0]     res_mean_reg, res_mean_next;
    logic [pdmc_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                            out_valid_reg, out_valid_next;
    logic [pdmc_pkg::MEAN_W-1:0]     out_mean_reg;
    logic [pdmc_pkg::STATUS_W-1:0]   out_status_reg;

    logic [pdmc_pkg::NUM_W-1:0]      num;
    logic [pdmc_pkg::SUM_W+6:0]      sum_w;
    logic [pdmc_pkg::DIV_W:0]        rem_sh, dvs;
    logic                            qbit, load;

    assign q_busy       = state_reg != pdmc_pkg::Q_IDLE;
    assign m_valid      = out_valid_reg;
    assign m_mean_milli = out_mean_reg;
    assign m_status     = out_status_reg;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        s100_next       = s100_reg;
        lo_prod_next    = lo_prod_reg;
        hi_prod_next    = hi_prod_reg;
        rem_next        = rem_reg;
        numlo_next      = numlo_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        res_mean_next   = res_mean_reg;
        res_status_next = res_status_reg;
        load            = 1'b0;
        sum_w           = pdmc_pkg::PROD_W'(sum_reg);
        // rounded mean = (2*s100 + cnt) / (2*cnt)
        num    = pdmc_pkg::NUM_W'({s100_reg, 1'b0}) + pdmc_pkg::NUM_W'(cnt_reg);
        dvs    = (pdmc_pkg::DIV_W+1)'({cnt_reg, 1'b0});
        rem_sh = {rem_reg, numlo_reg[pdmc_pkg::QUO_W-1]};
        qbit   = rem_sh >= dvs;
        case (state_reg)
            pdmc_pkg::Q_IDLE: begin
                if (q_start) begin
                    cnt_next = q_req.acc.cnt;
                    sum_next = q_req.acc.sum;
                    if (!q_req.seen || !q_req.ch_ok) begin
                        res_mean_next   = '0;
                        res_status_next = pdmc_pkg::ST_NODATA;
                        state_next      = pdmc_pkg::Q_DONE;
                    end else if (q_req.acc.cnt < pdmc_pkg::CNT_W'(cfg.min_counts)) begin
                        res_mean_next   = pdmc_pkg::MEAN_FEW;
                        res_status_next = pdmc_pkg::ST_FEW;
                        state_next      = pdmc_pkg::Q_DONE;
                    end else if (q_req.acc.cnt == '0) begin
                        res_mean_next   = '0;
                        res_status_next = pdmc_pkg::ST_NODATA;
                        state_next      = pdmc_pkg::Q_DONE;
                    end else begin
                        state_next = pdmc_pkg::Q_MUL;
                    end
                end
            end
            pdmc_pkg::Q_MUL: begin
                s100_next    = (sum_w << 6) + (sum_w << 5) + (sum_w << 2);
                lo_prod_next = pdmc_pkg::PROD_W'(cfg.low_limit) * pdmc_pkg::PROD_W'(cnt_reg);
                hi_prod_next = pdmc_pkg::PROD_W'(cfg.high_limit) * pdmc_pkg::PROD_W'(cnt_reg);
                state_next   = pdmc_pkg::Q_CMP;
            end
            pdmc_pkg::Q_CMP: begin
                if (s100_reg < lo_prod_reg || s100_reg > hi_prod_reg) begin
                    res_mean_next   = pdmc_pkg::MEAN_OUT;
                    res_status_next = pdmc_pkg::ST_OUT;
                    state_next      = pdmc_pkg::Q_DONE;
                end else begin
                    rem_next   = num[pdmc_pkg::DIV_W+pdmc_pkg::QUO_W-1:pdmc_pkg::QUO_W];
                    numlo_next = num[pdmc_pkg::QUO_W-1:0];
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = pdmc_pkg::Q_DIV;
                end
            end
            pdmc_pkg::Q_DIV: begin
                rem_next   = qbit ? pdmc_pkg::DIV_W'(rem_sh - dvs)
                                  : rem_sh[pdmc_pkg::DIV_W-1:0];
                numlo_next = {numlo_reg[pdmc_pkg::QUO_W-2:0], 1'b0};
                quo_next   = {quo_reg[pdmc_pkg::QUO_W-2:0], qbit};
                step_next  = step_reg + 1'b1;
                if (step_reg == pdmc_pkg::STEP_W'(pdmc_pkg::QUO_W - 1)) begin
                    res_mean_next   = {quo_reg[pdmc_pkg::QUO_W-2:0], qbit};
                    res_status_next = pdmc_pkg::ST_OK;
                    state_next      = pdmc_pkg::Q_DONE;
                end
            end
            pdmc_pkg::Q_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    load       = 1'b1;
                    state_next = pdmc_pkg::Q_IDLE;
                end
            end
            default: begin
                state_next = pdmc_pkg::Q_IDLE;
            end
        endcase
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pdmc_pkg::Q_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        sum_reg        <= sum_next;
        s100_reg       <= s100_next;
        lo_prod_reg    <= lo_prod_next;
        hi_prod_reg    <= hi_prod_next;
        rem_reg        <= rem_next;
        numlo_reg      <= numlo_next;
        quo_reg        <= quo_next;
        res_mean_reg   <= res_mean_next;
        res_status_reg <= res_status_next;
        if (load) begin
            out_mean_reg   <= res_mean_reg;
            out_status_reg <= res_status_reg;
        end
    end

endmodule
`default_nettype wire

// ----- src/per_channel_delay_mean_calibrator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// per_channel_delay_mean_calibrator
// Hit and event words: one per cycle unless a clearing pass or a busy mean unit
// holds the queue; the store is written from the execute register after a pop.
// Query: fallback answers skip the divider; a computed mean goes through the
// radix-2 divider; queries go one at a time. Reset: a store clearing pass with
// s_ready low; every 255th event word starts an event mark pass (words queue up).
// ----------------------------------------------------------------------------
module per_channel_delay_mean_calibrator #(
    parameter int CHANNELS = 2048
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [pdmc_pkg::CMD_W-1:0]       s_command,
    input  wire logic [pdmc_pkg::CHAN_W-1:0]      s_channel,
    input  wire logic [pdmc_pkg::TENTHS_W-1:0]    s_d80_tenths,
    input  wire logic                             s_hit_good,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [pdmc_pkg::MEAN_W-1:0]           m_mean_milli,
    output logic [pdmc_pkg::STATUS_W-1:0]         m_status,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pdmc_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [pdmc_pkg::PDATA_W-1:0]     pwdata,
    output logic [pdmc_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    pdmc_pkg::cfg_t   cfg_reg;
    logic             cfg_wr;
    logic             push, q_ready, init_busy, pop, head_valid, q_start, q_busy;
    pdmc_pkg::item_t  push_item, head;
    pdmc_pkg::qreq_t  q_req;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_limit  <= pdmc_pkg::LOW_LIMIT_RST;
            cfg_reg.high_limit <= pdmc_pkg::HIGH_LIMIT_RST;
            cfg_reg.min_counts <= pdmc_pkg::MIN_COUNTS_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pdmc_pkg::REG_LOW_LIMIT:  cfg_reg.low_limit  <= pwdata[pdmc_pkg::LIMIT_W-1:0];
                pdmc_pkg::REG_HIGH_LIMIT: cfg_reg.high_limit <= pwdata[pdmc_pkg::LIMIT_W-1:0];
                pdmc_pkg::REG_MIN_COUNTS: cfg_reg.min_counts <= pwdata[pdmc_pkg::MINC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pdmc_pkg::REG_LOW_LIMIT:  prdata = pdmc_pkg::PDATA_W'(cfg_reg.low_limit);
            pdmc_pkg::REG_HIGH_LIMIT: prdata = pdmc_pkg::PDATA_W'(cfg_reg.high_limit);
            pdmc_pkg::REG_MIN_COUNTS: prdata = pdmc_pkg::PDATA_W'(cfg_reg.min_counts);
            default:                  prdata = '0;
        endcase
    end

    pdmc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_channel    (s_channel),
        .s_d80_tenths (s_d80_tenths),
        .s_hit_good   (s_hit_good),
        .q_ready      (q_ready),
        .init_busy    (init_busy),
        .push         (push),
        .item         (push_item)
    );

    pdmc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .q_ready    (q_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    pdmc_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .init_busy  (init_busy),
        .q_start    (q_start),
        .q_req      (q_req),
        .q_busy     (q_busy)
    );

    pdmc_query u_query (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_start      (q_start),
        .q_req        (q_req),
        .cfg          (cfg_reg),
        .q_busy       (q_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mean_milli (m_mean_milli),
        .m_status     (m_status)
    );

endmodule
`default_nettype wire

// ----- src/pdmc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdmc_checker
// Port-level checks on the calibrator: result word hold, fallback values
// tied to their status codes, and input held off as the clearing pass begins.
// ----------------------------------------------------------------------------
module pdmc_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [pdmc_pkg::MEAN_W-1:0]       m_mean_milli,
    input wire logic [pdmc_pkg::STATUS_W-1:0]     m_status
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_milli) && $stable(m_status))
        else $error("result word changed while stalled");

    a_few_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == pdmc_pkg::ST_FEW) |-> m_mean_milli == pdmc_pkg::MEAN_FEW)
        else $error("too-few status with wrong mean");

    a_out_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == pdmc_pkg::ST_OUT) |-> m_mean_milli == pdmc_pkg::MEAN_OUT)
        else $error("out-of-limits status with wrong mean");

    a_nodata_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == pdmc_pkg::ST_NODATA) |-> m_mean_milli == '0)
        else $error("no-data status with nonzero mean");

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) == 1'b0 |-> !s_ready)
        else $error("input accepted before store clearing pass");

endmodule

bind per_channel_delay_mean_calibrator pdmc_checker u_pdmc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_mean_milli (m_mean_milli),
    .m_status     (m_status)
);
`default_nettype wire
